// ===== design/plti_pkg.sv =====
// Shared constants, codes and control/status types of the table interpolator.
package plti_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int SPD_W   = 12;
  localparam int PWR_W   = 13;
  localparam int SHAFT_W = 16;
  localparam int N_W     = 20;
  localparam int RES_W   = 20;
  localparam int NUM_W   = 35;
  localparam int DEN_W   = 17;
  localparam int DVD_W   = 34;
  localparam int DVS_W   = 16;
  localparam int SUM_W   = 36;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_DATA_W = 12;

  // 30/pi in Q16, rounded to nearest
  localparam logic [19:0] RPM_PER_RADS_Q16 = 20'd625823;
  localparam logic [36:0] CONV_ROUND       = 37'd32768;
  localparam logic [SPD_W-1:0] MIN_SPEED_RESET = 12'd350;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_MIN_SPEED   = 1'b1;

  localparam logic RD_MID  = 1'b0;
  localparam logic RD_NEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_FEW   = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    conv;
    logic    srch_init;
    logic    srch_upd;
    logic    rd_sel;
    logic    lat0;
    logic    calc;
    logic    div_start;
    logic    load_out;
    logic    use_res;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic few;
    logic below;
    logic srch_done;
    logic zero_width;
    logic div_done;
  } sts_t;

endpackage

// ===== design/plti_div.sv =====
// Restoring divider, one quotient bit per cycle.
module plti_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [plti_pkg::DVD_W-1:0] dividend,
  input  logic [plti_pkg::DVS_W-1:0] divisor,
  output logic [plti_pkg::DVD_W-1:0] quotient,
  output logic                      done
);
  import plti_pkg::*;

  logic [DVD_W-1:0]     q_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;

  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_r <= diff[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// ===== design/plti_ctrl.sv =====
// Sequencer for table writes and queries: search, fetch, divide, emit.
module plti_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  plti_pkg::sts_t  sts,
  output plti_pkg::cmd_t  cmd
);
  import plti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_CHECK, S_SRCH, S_SCMP, S_FET0, S_FET1, S_FET2,
    S_PREP, S_DIV, S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    use_r, use_nxt;
  logic    ovalid_r, ovalid_nxt;
  logic    accept;
  logic    can_load;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign can_load   = !ovalid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    code_nxt   = code_r;
    use_nxt    = use_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.rd_sel = RD_MID;
    cmd.code   = code_r;
    cmd.use_res = use_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          code_nxt    = ST_OK;
          use_nxt     = 1'b0;
          state_nxt   = sts.is_write ? S_EMIT : S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // too few points takes precedence over the speed check
        if (sts.few) begin
          code_nxt  = ST_FEW;
          state_nxt = S_EMIT;
        end else if (sts.below) begin
          code_nxt  = ST_BELOW;
          state_nxt = S_EMIT;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        state_nxt = sts.srch_done ? S_FET0 : S_SCMP;
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_FET0: begin
        state_nxt = S_FET1;
      end
      S_FET1: begin
        cmd.lat0   = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_nxt  = S_FET2;
      end
      S_FET2: begin
        if (sts.zero_width) begin
          code_nxt  = ST_ZERO;
          state_nxt = S_EMIT;
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          code_nxt  = ST_OK;
          use_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      code_r   <= ST_OK;
      use_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      code_r   <= code_nxt;
      use_r    <= use_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== design/plti_dp.sv =====
// Datapath: point table, config registers, speed conversion, search and interpolation.
module plti_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  plti_pkg::cmd_t                cmd,
  output plti_pkg::sts_t                sts,
  input  logic                          in_command,
  input  logic [3:0]                    in_point_index,
  input  logic [plti_pkg::SPD_W-1:0]    in_point_speed_rpm,
  input  logic [plti_pkg::PWR_W-1:0]    in_point_power_kw,
  input  logic [plti_pkg::SHAFT_W-1:0]  in_shaft_speed,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [plti_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic signed [plti_pkg::RES_W-1:0] ref_power,
  output logic [1:0]                    status
);
  import plti_pkg::*;

  // configuration
  logic [4:0]       point_count_r;
  logic [SPD_W-1:0] min_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      min_speed_r   <= MIN_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count_r <= cfg_data[4:0];
        CFG_MIN_SPEED:   min_speed_r   <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // point table: one write port, one registered read port
  logic [SPD_W-1:0] spd_mem [MAX_POINTS];
  logic [PWR_W-1:0] pwr_mem [MAX_POINTS];
  logic [SPD_W-1:0] rd_spd_r;
  logic [PWR_W-1:0] rd_pwr_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  assign wr_en = cmd.capture && (in_command == CMD_WRITE) &&
                 (32'(in_point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spd_mem[IDX_W'(in_point_index)] <= in_point_speed_rpm;
      pwr_mem[IDX_W'(in_point_index)] <= in_point_power_kw;
    end
    rd_spd_r <= spd_mem[rd_addr];
    rd_pwr_r <= pwr_mem[rd_addr];
  end

  // speed conversion to rpm in Q.8
  logic [SHAFT_W-1:0] shaft_r;
  logic [N_W-1:0]     n_r;
  logic [36:0]        conv_sum;

  assign conv_sum = 37'(shaft_r) * 37'(RPM_PER_RADS_Q16) + CONV_ROUND;

  always_ff @(posedge clk) begin
    if (cmd.capture) shaft_r <= in_shaft_speed;
    if (cmd.conv)    n_r     <= conv_sum[35:16];
  end

  // points in use, clamped to the table depth
  logic [31:0]      cnt_full;
  logic [CNT_W-1:0] cnt;

  assign cnt_full = (32'(point_count_r) > MAX_POINTS) ? MAX_POINTS : 32'(point_count_r);
  assign cnt      = CNT_W'(cnt_full);

  // binary search
  logic [IDX_W-1:0] l_r, r_r;
  logic [IDX_W:0]   lr_sum;
  logic [IDX_W-1:0] mid;

  assign lr_sum  = {1'b0, l_r} + {1'b0, r_r};
  assign mid     = lr_sum[IDX_W:1];
  assign rd_addr = (cmd.rd_sel == RD_NEXT) ? (mid + IDX_W'(1)) : mid;

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      l_r <= '0;
      r_r <= IDX_W'(cnt - CNT_W'(1));
    end else if (cmd.srch_upd) begin
      if (n_r <= {rd_spd_r, 8'b0}) r_r <= mid;
      else                         l_r <= mid;
    end
  end

  // interpolation terms
  logic [SPD_W-1:0]        s0_r;
  logic [PWR_W-1:0]        p0_r;
  logic signed [PWR_W:0]   dp;
  logic signed [N_W:0]     dx;
  logic signed [SPD_W:0]   dn;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DEN_W-1:0] den_r;

  assign dp = $signed({1'b0, rd_pwr_r}) - $signed({1'b0, p0_r});
  assign dx = $signed({1'b0, n_r}) - $signed({1'b0, s0_r, 8'b0});
  assign dn = $signed({1'b0, rd_spd_r}) - $signed({1'b0, s0_r});

  always_ff @(posedge clk) begin
    if (cmd.lat0) begin
      s0_r <= rd_spd_r;
      p0_r <= rd_pwr_r;
    end
    if (cmd.calc) begin
      num_r <= dp * dx;
      den_r <= {dn, 4'b0};
    end
  end

  // rounding division, ties away from zero, on magnitudes
  logic             neg_r;
  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad;
  logic [DVD_W-1:0] dividend;
  logic [DVD_W-1:0] quot;
  logic             div_done;

  assign an       = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign ad       = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign dividend = an[DVD_W-1:0] + DVD_W'(ad[DVS_W-1:1]);

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= num_r[NUM_W-1] ^ den_r[DEN_W-1];
  end

  plti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (ad[DVS_W-1:0]),
    .quotient (quot),
    .done     (div_done)
  );

  // final sum and saturation
  logic signed [SUM_W-1:0] q_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [RES_W-1:0] sat;

  assign q_ext = $signed({2'b0, quot});
  assign sum   = $signed(SUM_W'({p0_r, 4'b0})) + (neg_r ? -q_ext : q_ext);

  always_comb begin
    if (sum > $signed(SUM_W'(524287)))       sat = RES_W'(524287);
    else if (sum < -$signed(SUM_W'(524288))) sat = RES_W'(-524288);
    else                                     sat = sum[RES_W-1:0];
  end

  // output register
  logic signed [RES_W-1:0] power_r;
  logic [1:0]              status_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      power_r  <= cmd.use_res ? sat : '0;
      status_r <= cmd.code;
    end
  end

  assign ref_power = power_r;
  assign status    = status_r;

  assign sts.is_write   = (in_command == CMD_WRITE);
  assign sts.few        = (cnt < CNT_W'(2));
  assign sts.below      = (n_r < {min_speed_r, 8'b0});
  assign sts.srch_done  = (mid == l_r);
  assign sts.zero_width = (rd_spd_r == s0_r);
  assign sts.div_done   = div_done;

endmodule

// ===== design/piecewise_linear_table_interpolator.sv =====
// Piecewise-linear power table interpolator with write and query commands.
//
// Input stream (in_*): in_tuser is the command, 0 writes a table point and 1
// queries. in_tdata carries point index, point speed, point power and shaft
// speed. Every request gives exactly one result on the out_* stream:
// out_tdata is the saturated power in 1/16 kW, out_tuser the status code.
// Configuration (cfg_*) writes the point count (index 0) and the minimum
// speed (index 1); it is always ready. It is to be used only while the block is
// idle: the user is bound to this, the block itself does not enforce it. A write
// result goes straight to the output register; a query's time is set mainly
// by the bit-serial divider and the table search steps; early exits skip the divider.
// One request is in flight at a time; the next is taken once the result has
// moved into the output register, so a stalled receiver holds one result
// while a new request is processed, then the block waits at its output.
// Reset: point count 0, minimum speed 350 rpm, no result pending; table
// contents are undefined until written.
module piecewise_linear_table_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // point_index[3:0], point_speed_rpm[15:4],
                                  // point_power_kw[28:16], shaft_speed[44:29]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // ref_power[19:0]
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import plti_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [RES_W-1:0] ref_power;
  logic [1:0] status;

  assign cfg_ready = 1'b1;

  plti_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  plti_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_tuser),
    .in_point_index     (in_tdata[3:0]),
    .in_point_speed_rpm (in_tdata[15:4]),
    .in_point_power_kw  (in_tdata[28:16]),
    .in_shaft_speed     (in_tdata[44:29]),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .ref_power          (ref_power),
    .status             (status)
  );

  assign out_tdata = {4'b0, ref_power};
  assign out_tuser = status;

endmodule

// ===== dv/tb_piecewise_linear_table_interpolator.sv =====
// Self-checking testbench of the piecewise-linear power table interpolator.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interpolator;
  import plti_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_TARGET  = 600;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic              is_cfg;
    logic              cfg_idx;
    logic [11:0]       cfg_val;
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [SPD_W-1:0]  spd;
    logic [PWR_W-1:0]  pwr;
    logic [SHAFT_W-1:0] shaft;
    logic              calm;
  } plti_req_t;

  typedef struct packed {
    logic [RES_W-1:0] power;
    status_t          st;
  } power_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = CMD_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_POINT_COUNT;
  logic [11:0] cfg_data   = '0;

  // predictor state, updated at each accepted request / register write
  logic [SPD_W-1:0] tbl_spd [MAX_POINTS];
  logic [PWR_W-1:0] tbl_pwr [MAX_POINTS];
  logic [4:0]       tbl_count = '0;
  logic [SPD_W-1:0] tbl_min   = MIN_SPEED_RESET;

  plti_req_t     req_q[$];
  power_result_t ref_power_q[$];

  int   errors     = 0;
  int   n_items    = 0;
  int   n_results  = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;
  bit   gen_calm   = 1'b0;
  logic quiet      = 1'b0;
  int   cycle_cnt  = 0;

  piecewise_linear_table_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected power for a query against the current table and registers.
  function automatic power_result_t interp_power(logic [SHAFT_W-1:0] shaft);
    longint        n, s0, s1, p0, p1, dn, num, den, an, ad, q, acc;
    int            cnt, lo, hi, mid;
    power_result_t r;
    r.power = '0;
    r.st    = ST_OK;
    cnt = (tbl_count > MAX_POINTS) ? MAX_POINTS : int'(tbl_count);
    if (cnt < 2) begin
      r.st = ST_FEW;
      return r;
    end
    n = (longint'(shaft) * longint'(RPM_PER_RADS_Q16) + 32768) >>> 16;
    if (n < longint'(tbl_min) * 256) begin
      r.st = ST_BELOW;
      return r;
    end
    lo  = 0;
    hi  = cnt - 1;
    mid = (lo + hi) / 2;
    while (mid != lo) begin
      if (n <= longint'(tbl_spd[mid]) * 256) hi = mid;
      else lo = mid;
      mid = (lo + hi) / 2;
    end
    s0 = tbl_spd[mid];
    s1 = tbl_spd[mid + 1];
    p0 = tbl_pwr[mid];
    p1 = tbl_pwr[mid + 1];
    dn = s1 - s0;
    if (dn == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    num = (p1 - p0) * (n - s0 * 256);
    den = dn * 16;
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (an + ad / 2) / ad;
    if ((num < 0) != (den < 0)) q = -q;
    acc = p0 * 16 + q;
    if (acc > 524287) acc = 524287;
    if (acc < -524288) acc = -524288;
    r.power = acc[RES_W-1:0];
    return r;
  endfunction

  task automatic push_write(input int idx, input int spd, input int pwr);
    plti_req_t r;
    r       = '0;
    r.cmd   = CMD_WRITE;
    r.idx   = idx[IDX_W-1:0];
    r.spd   = spd[SPD_W-1:0];
    r.pwr   = pwr[PWR_W-1:0];
    r.shaft = SHAFT_W'($urandom_range(0, 65535));
    r.calm  = gen_calm;
    req_q   = {req_q, r};
    n_items++;
  endtask

  task automatic push_query(input int shaft);
    plti_req_t r;
    r       = '0;
    r.cmd   = CMD_QUERY;
    r.idx   = IDX_W'($urandom_range(0, MAX_POINTS - 1));
    r.spd   = SPD_W'($urandom_range(0, 4095));
    r.pwr   = PWR_W'($urandom_range(0, 8191));
    r.shaft = shaft[SHAFT_W-1:0];
    r.calm  = gen_calm;
    req_q   = {req_q, r};
    n_items++;
  endtask

  task automatic push_cfg(input logic idx, input int val);
    plti_req_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val[11:0];
    r.calm    = gen_calm;
    req_q     = {req_q, r};
  endtask

  // Driver: requests and register writes from req_q; registers only when drained.
  always @(posedge clk) begin : drive
    plti_req_t     head;
    power_result_t res;
    logic          in_sent, cfg_sent, nxt_in, nxt_cfg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      tbl_count = '0;
      tbl_min   = MIN_SPEED_RESET;
      gap_left  = 0;
    end else begin
      in_sent  = in_tvalid && in_tready;
      cfg_sent = cfg_valid && cfg_ready;
      if (in_sent) begin
        if (in_tuser == CMD_WRITE) begin
          tbl_spd[in_tdata[3:0]] = in_tdata[15:4];
          tbl_pwr[in_tdata[3:0]] = in_tdata[28:16];
          res.power = '0;
          res.st    = ST_OK;
        end else begin
          res = interp_power(in_tdata[44:29]);
        end
        ref_power_q = {ref_power_q, res};
      end
      if (cfg_sent) begin
        if (cfg_index == CFG_POINT_COUNT) tbl_count = cfg_data[4:0];
        else tbl_min = cfg_data;
      end
      nxt_in  = in_tvalid && !in_sent;
      nxt_cfg = cfg_valid && !cfg_sent;
      if (!nxt_in && !nxt_cfg && req_q.size() != 0) begin
        head = req_q[0];
        if (head.is_cfg) begin
          if (ref_power_q.size() == 0) begin
            void'(req_q.pop_front());
            cfg_index <= head.cfg_idx;
            cfg_data  <= head.cfg_val;
            nxt_cfg = 1'b1;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (!head.calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
        end else begin
          void'(req_q.pop_front());
          in_tdata <= {3'b000, head.shaft, head.pwr, head.spd, head.idx};
          in_tuser <= head.cmd;
          quiet    <= head.calm;
          nxt_in = 1'b1;
        end
      end
      in_tvalid <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: checks each result against the oldest expectation, drives ready.
  always @(posedge clk) begin : monitor
    power_result_t want;
    logic          nxt_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (ref_power_q.size() == 0) begin
          $error("unexpected result: ref_power %0d status %0d",
                 $signed(out_tdata[RES_W-1:0]), out_tuser);
          errors++;
        end else begin
          want = ref_power_q.pop_front();
          if (out_tdata[RES_W-1:0] !== want.power) begin
            $error("ref_power mismatch: expected %0d, actual %0d",
                   $signed(want.power), $signed(out_tdata[RES_W-1:0]));
            errors++;
          end
          if (out_tuser !== want.st) begin
            $error("status mismatch: expected %0d, actual %0d", want.st, out_tuser);
            errors++;
          end
        end
      end
      // one long hold-off while the sender is offering, to back up the input
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && n_results >= 150 && in_tvalid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 2);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stim
    int shape, spd, step, cnt_val, min_val, nq, k;

    // directed: count 0 gives too few points
    push_query(65535);
    // fill every entry so no query can read an unwritten one
    push_write(0, 0, 0);
    push_write(1, 400, 8191);
    push_write(2, 400, 100);
    for (k = 3; k < 15; k++) push_write(k, 200 * k, 500 * k);
    push_write(15, 4095, 8191);
    push_cfg(CFG_POINT_COUNT, 1);
    push_query(30000);
    push_cfg(CFG_POINT_COUNT, 16);
    push_query(0);          // below minimum speed
    push_query(65535);      // top of the speed range
    push_query(12345);
    push_cfg(CFG_MIN_SPEED, 0);
    push_query(0);
    push_cfg(CFG_POINT_COUNT, 3);
    push_query(40000);      // lands on the equal-speed pair
    push_cfg(CFG_POINT_COUNT, 2);
    push_query(65535);      // steep rise, saturates high
    push_write(2, 401, 0);
    push_cfg(CFG_POINT_COUNT, 3);
    push_query(65535);      // steep fall, saturates low
    push_cfg(CFG_MIN_SPEED, 4095);
    push_query(65535);

    // random phases: new registers, often a new table, then mixed traffic
    while (n_items < ITEM_TARGET) begin
      gen_calm = (n_items > ITEM_TARGET - 70) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       cnt_val = 0;
        1:       cnt_val = 1;
        2:       cnt_val = 2;
        3:       cnt_val = 16;
        default: cnt_val = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       min_val = 0;
        1:       min_val = 4095;
        2:       min_val = $urandom_range(0, 4095);
        default: min_val = $urandom_range(0, 600);
      endcase
      push_cfg(CFG_POINT_COUNT, cnt_val);
      push_cfg(CFG_MIN_SPEED, min_val);
      if ($urandom_range(0, 2) != 0) begin
        shape = $urandom_range(0, 9);
        spd   = $urandom_range(0, 300);
        for (k = 0; k < MAX_POINTS; k++) begin
          if (shape == 8) begin
            spd = $urandom_range(0, 4095);      // unsorted table
          end else if (k > 0) begin
            if (shape == 7) step = $urandom_range(0, 1) ? 0 : $urandom_range(1, 300);
            else if (shape == 9) step = $urandom_range(150, 390);
            else step = $urandom_range(1, 340);
            spd = (spd + step > 4095) ? 4095 : spd + step;
          end
          push_write(k, spd, $urandom_range(0, 8191));
        end
      end
      nq = $urandom_range(30, 60);
      for (k = 0; k < nq; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_write($urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 4095),
                     $urandom_range(0, 8191));
        end else begin
          case ($urandom_range(0, 15))
            0:       push_query(0);
            1:       push_query(65535);
            default: push_query($urandom_range(0, 65535));
          endcase
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid || cfg_valid) @(posedge clk);
    while (ref_power_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
